// ===== hdl/u8d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package u8d_pkg;

  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_BAD_LEAD  = 3'd2,
    ST_BAD_CONT  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_IGNORED   = 3'd5
  } status_t;

  localparam int CP_W   = 21;
  localparam int BYTE_W = 8;
  localparam int REM_W  = 2;

  typedef struct packed {
    status_t           status;
    logic [CP_W-1:0]   char_cp;
    logic              multibyte_part;
  } result_t;

endpackage

// ===== hdl/u8d_core.sv =====
`timescale 1ns / 1ps
// Per-byte decode logic and the decoder state (remaining count, partial code
// point, error flag). Depends on u8d_pkg.
module u8d_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [u8d_pkg::BYTE_W-1:0] data_byte,
  input  logic                      end_of_stream,
  output u8d_pkg::result_t          result
);
  import u8d_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CP_W-1:0]  pcp_r, pcp_nxt;
  logic             err_r, err_nxt;

  logic [CP_W-1:0]  pcp_shift;
  logic [REM_W-1:0] rem_dec;

  assign pcp_shift = {pcp_r[CP_W-7:0], data_byte[5:0]};
  assign rem_dec   = rem_r - REM_W'(1);

  always_comb begin
    rem_nxt               = rem_r;
    pcp_nxt               = pcp_r;
    err_nxt               = err_r;
    result.status         = ST_PENDING;
    result.char_cp        = '0;
    result.multibyte_part = 1'b0;

    if (err_r) begin
      result.status = ST_IGNORED;
    end else if (rem_r == '0) begin
      if (data_byte inside {[8'h00:8'h7F]}) begin
        result.status  = ST_COMPLETE;
        result.char_cp = CP_W'(data_byte);
      end else if (data_byte inside {[8'hC0:8'hDF]}) begin
        rem_nxt               = REM_W'(1);
        pcp_nxt               = CP_W'(data_byte[4:0]);
        result.multibyte_part = 1'b1;
      end else if (data_byte inside {[8'hE0:8'hEF]}) begin
        rem_nxt               = REM_W'(2);
        pcp_nxt               = CP_W'(data_byte[3:0]);
        result.multibyte_part = 1'b1;
      end else if (data_byte inside {[8'hF0:8'hF7]}) begin
        rem_nxt               = REM_W'(3);
        pcp_nxt               = CP_W'(data_byte[2:0]);
        result.multibyte_part = 1'b1;
      end else begin
        result.status = ST_BAD_LEAD;
        err_nxt       = 1'b1;
      end
      if (result.multibyte_part && end_of_stream) result.status = ST_TRUNCATED;
    end else begin
      if (data_byte inside {[8'h80:8'hBF]}) begin
        result.multibyte_part = 1'b1;
        rem_nxt               = rem_dec;
        if (rem_dec == '0) begin
          result.status  = ST_COMPLETE;
          result.char_cp = pcp_shift;
          pcp_nxt        = '0;
        end else begin
          pcp_nxt = pcp_shift;
          if (end_of_stream) result.status = ST_TRUNCATED;
        end
      end else begin
        result.status = ST_BAD_CONT;
        err_nxt       = 1'b1;
      end
    end

    // last word of a stream: everything back to idle
    if (end_of_stream) begin
      rem_nxt = '0;
      pcp_nxt = '0;
      err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      pcp_r <= '0;
      err_r <= 1'b0;
    end else if (step) begin
      rem_r <= rem_nxt;
      pcp_r <= pcp_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 stream decoder top level: input register, decode core, result register.
// The accepted byte goes through the input register, then its result into the result
// register. Throughput: one byte per cycle while out_tready does not stall the output.
// Reset (rst_n low, synchronous) empties both registers and clears the state.
// Depends on u8d_pkg and u8d_core.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [20:0] code point, [28:21] echo_byte, [31:29] zero
  output logic [3:0]  out_tuser,  // [2:0] status, [3] multibyte_part
  output logic        out_tlast   // stream_done
);
  import u8d_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_last_r;

  logic              out_valid_r;
  result_t           out_res_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic    adv;
  result_t res;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  u8d_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .data_byte     (in_byte_r),
    .end_of_stream (in_last_r),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r  <= res;
      out_byte_r <= in_byte_r;
      out_last_r <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_byte_r, out_res_r.char_cp};
  assign out_tuser  = {out_res_r.multibyte_part, out_res_r.status};
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/u8d_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on u8d_pkg and utf8_stream_decoder.
module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);
  import u8d_pkg::*;

  logic out_fire;
  logic err_r;

  assign out_fire = out_tvalid && out_tready;

  // tracks whether an error word has gone out in the current stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (out_fire) begin
      if (out_tlast) err_r <= 1'b0;
      else if (out_tuser[2:0] == ST_BAD_LEAD || out_tuser[2:0] == ST_BAD_CONT) err_r <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && err_r |-> out_tuser[2:0] == ST_IGNORED)
    else $error("word after error not marked ignored");

  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tuser[2:0] != ST_COMPLETE |-> out_tdata[20:0] == '0)
    else $error("code point set without a completed character");

  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tuser[2:0] == ST_COMPLETE && !out_tuser[3]
      |-> out_tdata[20:0] == {13'd0, out_tdata[28:21]} && !out_tdata[28])
    else $error("single-byte character does not match its byte");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
